### hw/rtl/sfsps_pkg.sv
`timescale 1ns / 1ps
package sfsps_pkg;

	localparam int NUM_CHANNELS_DEF = 8;
	localparam int CH_IDX_W         = 3;
	localparam int BANK_DEPTH       = 1 << CH_IDX_W;
	localparam int RAM_DEPTH        = 2 * BANK_DEPTH;
	localparam int RAM_ADDR_W       = CH_IDX_W + 1;
	localparam int WIDTH_W          = 8;
	localparam int BASE_W           = 8;
	localparam int TICK_W           = 12;
	localparam int CNT_W            = 4;
	localparam int PINS_W           = 8;
	localparam int CFG_DATA_W       = 12;

	localparam logic [BASE_W-1:0]  BASE_RESET  = 8'd30;
	localparam logic [TICK_W-1:0]  GAP_RESET   = 12'd2843;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 8'd150;

	typedef enum logic [0:0] {
		CFG_BASE = 1'b0,
		CFG_GAP  = 1'b1
	} cfg_idx_t;

	typedef enum logic [0:0] {
		MODE_TICK = 1'b0,
		MODE_BYTE = 1'b1
	} item_mode_t;

	typedef struct packed {
		logic                  we;
		logic [RAM_ADDR_W-1:0] addr;
		logic [WIDTH_W-1:0]    data;
	} wr_req_t;

	typedef struct packed {
		logic loaded;
		logic dropped;
	} frm_flags_t;

endpackage

### hw/rtl/sfsps_ram.sv
`timescale 1ns / 1ps
module sfsps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/sfsps_framer.sv
`timescale 1ns / 1ps
module sfsps_framer #(
	parameter int NUM_CHANNELS = sfsps_pkg::NUM_CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_take,
	input  logic [7:0]                    rx_byte,
	input  logic                          rx_overrun,
	output sfsps_pkg::wr_req_t            wr,
	output logic                          bank_d,
	output logic                          dflt_q,
	output sfsps_pkg::frm_flags_t         flags
);
	import sfsps_pkg::*;

	logic             col_q, col_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             bank_q;
	logic             dflt_d;
	logic [CNT_W-1:0] cnt_inc;

	assign cnt_inc = cnt_q + CNT_W'(1);

	always_comb begin
		col_d         = col_q;
		cnt_d         = cnt_q;
		bank_d        = bank_q;
		dflt_d        = dflt_q;
		wr.we         = 1'b0;
		wr.addr       = {~bank_q, cnt_q[CH_IDX_W-1:0]};
		wr.data       = rx_byte;
		flags.loaded  = 1'b0;
		flags.dropped = 1'b0;
		if (byte_take) begin
			// overrun aborts collection, then the byte goes to the hunter
			if (col_q && rx_overrun) begin
				flags.dropped = 1'b1;
			end
			if (!col_q || rx_overrun) begin
				col_d = (rx_byte == 8'd0);
				cnt_d = '0;
			end else begin
				// staging goes to the idle bank, a full frame swaps banks
				wr.we = 1'b1;
				cnt_d = cnt_inc;
				if (cnt_inc >= CNT_W'(NUM_CHANNELS)) begin
					col_d        = 1'b0;
					cnt_d        = '0;
					bank_d       = ~bank_q;
					dflt_d       = 1'b0;
					flags.loaded = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= 1'b0;
			cnt_q  <= '0;
			bank_q <= 1'b0;
			dflt_q <= 1'b1;
		end else begin
			col_q  <= col_d;
			cnt_q  <= cnt_d;
			bank_q <= bank_d;
			dflt_q <= dflt_d;
		end
	end

`ifndef SYNTHESIS
	a_hunt_cnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!col_q |-> cnt_q == '0) else $error("count nonzero while hunting");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(NUM_CHANNELS)) else $error("byte count out of range");
	a_load_swaps: assert property (@(posedge clk) disable iff (!arst_n)
		flags.loaded |=> bank_q != $past(bank_q)) else $error("load without bank swap");
`endif

endmodule

### hw/rtl/sfsps_pulse.sv
`timescale 1ns / 1ps
module sfsps_pulse #(
	parameter int NUM_CHANNELS = sfsps_pkg::NUM_CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                tick,
	input  logic [sfsps_pkg::WIDTH_W-1:0]       width,
	input  logic [sfsps_pkg::BASE_W-1:0]        base,
	input  logic [sfsps_pkg::TICK_W-1:0]        gap,
	output logic [sfsps_pkg::PINS_W-1:0]        pins,
	output logic [sfsps_pkg::CH_IDX_W-1:0]      rd_ch
);
	import sfsps_pkg::*;

	logic                in_pulse_q, in_pulse_d;
	logic [CH_IDX_W-1:0] active_q, active_d;
	logic [TICK_W-1:0]   ticks_q, ticks_d;
	logic [TICK_W-1:0]   len;
	logic                last_ch;

	assign len     = TICK_W'({1'b0, base} + {1'b0, width});
	assign last_ch = ({1'b0, active_q} + (CH_IDX_W+1)'(1)) >= (CH_IDX_W+1)'(NUM_CHANNELS);

	always_comb begin
		in_pulse_d = in_pulse_q;
		active_d   = active_q;
		ticks_d    = ticks_q;
		if (tick) begin
			if (ticks_q > TICK_W'(1)) begin
				ticks_d = ticks_q - TICK_W'(1);
			end else if (in_pulse_q) begin
				if (last_ch) begin
					in_pulse_d = 1'b0;
					active_d   = '0;
					ticks_d    = gap;
				end else begin
					active_d = active_q + CH_IDX_W'(1);
					ticks_d  = len;
				end
			end else begin
				in_pulse_d = 1'b1;
				active_d   = '0;
				ticks_d    = len;
			end
		end
	end

	// prefetch the width of the channel that the next state would load
	always_comb begin
		rd_ch = '0;
		if (in_pulse_d &&
		    ({1'b0, active_d} + (CH_IDX_W+1)'(1)) < (CH_IDX_W+1)'(NUM_CHANNELS)) begin
			rd_ch = active_d + CH_IDX_W'(1);
		end
	end

	assign pins = in_pulse_q ? (PINS_W'(1) << active_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pulse_q <= 1'b0;
			active_q   <= '0;
			ticks_q    <= GAP_RESET;
		end else begin
			in_pulse_q <= in_pulse_d;
			active_q   <= active_d;
			ticks_q    <= ticks_d;
		end
	end

`ifndef SYNTHESIS
	a_gap_ch0: assert property (@(posedge clk) disable iff (!arst_n)
		!in_pulse_q |-> active_q == '0) else $error("channel nonzero in gap");
	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, active_q} < (CH_IDX_W+1)'(NUM_CHANNELS)) else $error("channel out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!tick |=> $stable(ticks_q) && $stable(active_q)) else $error("state moved without tick");
`endif

endmodule

### hw/rtl/serial_fed_servo_pulse_sequencer.sv
`timescale 1ns / 1ps
// output: a result shows on the output in the cycle after its input transaction
// throughput: one item per cycle; the output register takes a new result while
// the old one leaves, so in_stall follows out_stall only when a result waits
// widths are prefetched from a double-banked ram ahead of use
// reset: asynchronous, widths read 150, base 30, gap 2843, gap phase, hunting
module serial_fed_servo_pulse_sequencer #(
	parameter int NUM_CHANNELS = sfsps_pkg::NUM_CHANNELS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 mode,
	input  logic [7:0]                           rx_byte,
	input  logic                                 rx_overrun,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [sfsps_pkg::PINS_W-1:0]         servo_pins,
	output logic                                 frame_loaded,
	output logic                                 frame_dropped,
	input  logic                                 cfg_we,
	input  logic [0:0]                           cfg_index,
	input  logic [sfsps_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import sfsps_pkg::*;

	logic                  take;
	logic                  tick;
	logic                  byte_take;
	logic [BASE_W-1:0]     base_q;
	logic [TICK_W-1:0]     gap_q;
	wr_req_t               wr;
	frm_flags_t            flags;
	logic                  bank_d;
	logic                  dflt_q;
	logic [CH_IDX_W-1:0]   rd_ch;
	logic [RAM_ADDR_W-1:0] raddr;
	logic [WIDTH_W-1:0]    rdata;
	logic                  hit_q;
	logic [WIDTH_W-1:0]    byp_q;
	logic [WIDTH_W-1:0]    width;
	logic [PINS_W-1:0]     pins;

	assign in_stall  = out_valid && out_stall;
	assign take      = in_valid && !in_stall;
	assign tick      = take && (mode == MODE_TICK);
	assign byte_take = take && (mode == MODE_BYTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			gap_q  <= GAP_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BASE: base_q <= cfg_data[BASE_W-1:0];
				CFG_GAP:  gap_q  <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	sfsps_framer #(.NUM_CHANNELS(NUM_CHANNELS)) u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_take  (byte_take),
		.rx_byte    (rx_byte),
		.rx_overrun (rx_overrun),
		.wr         (wr),
		.bank_d     (bank_d),
		.dflt_q     (dflt_q),
		.flags      (flags)
	);

	assign raddr = {bank_d, rd_ch};

	sfsps_ram #(.WIDTH(WIDTH_W), .DEPTH(RAM_DEPTH)) u_ram (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (raddr),
		.rdata (rdata)
	);

	// write to the entry being read in the same cycle is forwarded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= wr.we && (wr.addr == raddr);
		end
	end

	always_ff @(posedge clk) begin
		byp_q <= wr.data;
	end

	assign width = dflt_q ? WIDTH_RESET : (hit_q ? byp_q : rdata);

	sfsps_pulse #(.NUM_CHANNELS(NUM_CHANNELS)) u_pulse (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.width  (width),
		.base   (base_q),
		.gap    (gap_q),
		.pins   (pins),
		.rd_ch  (rd_ch)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!in_stall) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			servo_pins    <= pins;
			frame_loaded  <= flags.loaded;
			frame_dropped <= flags.dropped;
		end
	end

`ifndef SYNTHESIS
	a_pins_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(servo_pins)) else $error("more than one pin high");
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(frame_loaded && frame_dropped)) else $error("load and drop together");
	a_tick_no_flags: assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> !frame_loaded && !frame_dropped) else $error("flag on a tick");
`endif

endmodule
